// File: rtl/wet_pkg.sv
package wet_pkg;

	// number of wheels carried by one word
	localparam int WHEEL_COUNT = 4;

	// field widths
	localparam int ANGLE_W = 15;
	localparam int STEP_W  = 24;
	localparam int TICKS_W = 16;
	localparam int TICK_W  = 12;
	localparam int REM_W   = 13;
	localparam int SUM_W   = 17;
	localparam int MAG_W   = 16;
	localparam int CNT_W   = 4;

	// wrap handling in 1/80 degree
	localparam logic signed [TICKS_W-1:0] WRAP_LIMIT      = -16'sd14400;
	localparam logic signed [TICKS_W-1:0] FULL_TURN_UNITS = 16'sd28800;

	// tick register reset value
	localparam logic [TICK_W-1:0] TICK_SIZE_RESET = 12'd96;

	// last division step index
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAG_W - 1);

	typedef struct packed {
		logic               four_wheels;
		logic [STEP_W-1:0]  step_us;
		logic [ANGLE_W-1:0] angle_0;
		logic [ANGLE_W-1:0] angle_1;
		logic [ANGLE_W-1:0] angle_2;
		logic [ANGLE_W-1:0] angle_3;
	} wet_in_t;

	typedef struct packed {
		logic [STEP_W-1:0]         step_us_out;
		logic signed [TICKS_W-1:0] ticks_0;
		logic signed [TICKS_W-1:0] ticks_1;
		logic signed [TICKS_W-1:0] ticks_2;
		logic signed [TICKS_W-1:0] ticks_3;
	} wet_out_t;

	// lane control from the sequencer
	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} wet_ctl_t;

endpackage

// File: rtl/wheel_encoder_tick_emulator_unit.sv
// an accepted four-wheel word is loaded into the lanes, divided and committed to the output register
// in_stall stays high until that commit, while the 16-step bit-serial divider in each lane runs
// a word with four_wheels clear is taken without making the block busy and yields no result
// the output register lets a result wait while the next word is already taken
// reset: async active low, clears angles, remainders, control, tick_size to 96
module wheel_encoder_tick_emulator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  wet_pkg::wet_in_t             in_word,
	output logic                         out_valid,
	input  logic                         out_stall,
	output wet_pkg::wet_out_t            out_word,
	input  logic                         cfg_we,
	input  logic [wet_pkg::TICK_W-1:0]   cfg_data
);

	logic [wet_pkg::TICK_W-1:0]        tick_size_q;
	logic [wet_pkg::STEP_W-1:0]        step_q;
	logic [wet_pkg::CNT_W-1:0]         cnt_q;
	logic                              busy_q;
	logic                              fin_q;
	logic                              accept;
	logic                              free;
	logic [wet_pkg::TICK_W-1:0]        divisor;
	wet_pkg::wet_ctl_t                 ctl;
	logic [wet_pkg::ANGLE_W-1:0]       angles [wet_pkg::WHEEL_COUNT];
	logic signed [wet_pkg::TICKS_W-1:0] ticks [wet_pkg::WHEEL_COUNT];

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign divisor  = (tick_size_q == '0) ? wet_pkg::TICK_W'(1) : tick_size_q;

	// sequencer control to lanes
	always_comb begin
		ctl.load   = accept && in_word.four_wheels;
		ctl.step   = busy_q && !fin_q;
		ctl.commit = busy_q && fin_q && free;
	end

	// angle fields by lane
	assign angles[0] = in_word.angle_0;
	assign angles[1] = in_word.angle_1;
	assign angles[2] = in_word.angle_2;
	assign angles[3] = in_word.angle_3;

	// tick size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_size_q <= wet_pkg::TICK_SIZE_RESET;
		end else if (cfg_we) begin
			tick_size_q <= cfg_data;
		end
	end

	// division step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.load) begin
			busy_q <= 1'b1;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.step) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == wet_pkg::LAST_STEP) begin
				fin_q <= 1'b1;
			end
		end else if (ctl.commit) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
		end
	end

	// time step held for the result word
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			step_q <= in_word.step_us;
		end
	end

	// one divider lane per wheel
	for (genvar g = 0; g < wet_pkg::WHEEL_COUNT; g++) begin : g_lane
		wet_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.angle   (angles[g]),
			.divisor (divisor),
			.ticks   (ticks[g])
		);
	end

	// merge lane results into the output word
	wet_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (ctl.commit),
		.step_us   (step_q),
		.ticks     (ticks),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// File: rtl/wet_lane.sv
module wet_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wet_pkg::wet_ctl_t                   ctl,
	input  logic [wet_pkg::ANGLE_W-1:0]         angle,
	input  logic [wet_pkg::TICK_W-1:0]          divisor,
	output logic signed [wet_pkg::TICKS_W-1:0]  ticks
);

	logic [wet_pkg::ANGLE_W-1:0]       prev_q;
	logic signed [wet_pkg::REM_W-1:0]  rem_q;
	logic [wet_pkg::MAG_W-1:0]         quo_q;
	logic [wet_pkg::TICK_W-1:0]        part_q;
	logic                              neg_q;

	logic signed [wet_pkg::TICKS_W-1:0] diff;
	logic signed [wet_pkg::TICKS_W-1:0] diff_wrap;
	logic signed [wet_pkg::SUM_W-1:0]   sum;
	logic [wet_pkg::SUM_W-1:0]          sum_neg;
	logic [wet_pkg::MAG_W-1:0]          mag;
	logic [wet_pkg::TICK_W:0]           trial;
	logic [wet_pkg::TICK_W:0]           trial_sub;
	logic                               fits;
	logic [wet_pkg::REM_W-1:0]          rem_next;
	logic [wet_pkg::MAG_W-1:0]          quo_neg;

	// angle change with wrap, added to the carried remainder
	always_comb begin
		diff = wet_pkg::TICKS_W'($signed({1'b0, angle}) - $signed({1'b0, prev_q}));
		diff_wrap = (diff < wet_pkg::WRAP_LIMIT) ? diff + wet_pkg::FULL_TURN_UNITS : diff;
		sum = wet_pkg::SUM_W'(rem_q) + wet_pkg::SUM_W'(diff_wrap);
		sum_neg = -sum;
		mag = sum[wet_pkg::SUM_W-1] ? sum_neg[wet_pkg::MAG_W-1:0] : sum[wet_pkg::MAG_W-1:0];
	end

	// one restoring division step
	always_comb begin
		trial = {part_q, quo_q[wet_pkg::MAG_W-1]};
		fits = trial >= {1'b0, divisor};
		trial_sub = trial - {1'b0, divisor};
	end

	// signed quotient with saturation, remainder keeps the dividend sign
	always_comb begin
		quo_neg = -quo_q;
		if (neg_q) begin
			if (quo_q > 16'd32768) begin
				ticks = -16'sd32768;
			end else begin
				ticks = $signed(quo_neg);
			end
			rem_next = -{1'b0, part_q};
		end else begin
			if (quo_q > 16'd32767) begin
				ticks = 16'sd32767;
			end else begin
				ticks = $signed(quo_q);
			end
			rem_next = {1'b0, part_q};
		end
	end

	// lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			rem_q  <= '0;
		end else begin
			if (ctl.load) begin
				prev_q <= angle;
			end
			if (ctl.commit) begin
				rem_q <= $signed(rem_next);
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quo_q  <= mag;
			part_q <= '0;
			neg_q  <= sum[wet_pkg::SUM_W-1];
		end else if (ctl.step) begin
			quo_q  <= {quo_q[wet_pkg::MAG_W-2:0], fits};
			part_q <= fits ? trial_sub[wet_pkg::TICK_W-1:0] : trial[wet_pkg::TICK_W-1:0];
		end
	end

endmodule

// File: rtl/wet_merge.sv
module wet_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  logic [wet_pkg::STEP_W-1:0]         step_us,
	input  logic signed [wet_pkg::TICKS_W-1:0] ticks [wet_pkg::WHEEL_COUNT],
	output logic                               free,
	output logic                               out_valid,
	input  logic                               out_stall,
	output wet_pkg::wet_out_t                  out_word
);

	logic              valid_q;
	wet_pkg::wet_out_t word_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// gather lane results into one word
	always_ff @(posedge clk) begin
		if (load) begin
			word_q.step_us_out <= step_us;
			word_q.ticks_0     <= ticks[0];
			word_q.ticks_1     <= ticks[1];
			word_q.ticks_2     <= ticks[2];
			word_q.ticks_3     <= ticks[3];
		end
	end

endmodule

// File: rtl/wet_checker.sv
module wet_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input wet_pkg::wet_in_t  in_word,
	input logic              out_valid,
	input logic              out_stall,
	input wet_pkg::wet_out_t out_word
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled result word changed");

	// a four-wheel word keeps the block busy on the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_word.four_wheels |=> in_stall)
		else $error("block not busy after taking a word");

	// an ignored word leaves the block free
	a_free_after_skip: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !in_word.four_wheels |=> !in_stall)
		else $error("block busy after ignored word");

	// a new result only appears while a word is in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a word in work");

endmodule

bind wheel_encoder_tick_emulator_unit wet_checker u_wet_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

// File: dv/tb_wheel_encoder_tick_emulator_unit.sv
`timescale 1ns / 100ps

module tb_wheel_encoder_tick_emulator_unit;

	localparam int FULL_TURN      = 28800;
	localparam int WRAP_DROP      = -14400;
	localparam int TICKS_MAX      = 32767;
	localparam int TICKS_MIN      = -32768;
	localparam int ANGLE_TOP      = 32767;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 3000;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	wet_pkg::wet_in_t            in_word   = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	wet_pkg::wet_out_t           out_word;
	logic                        cfg_we    = 1'b0;
	logic [wet_pkg::TICK_W-1:0]  cfg_data  = '0;

	// words waiting to be sent and tick counts waiting to come back
	wet_pkg::wet_in_t  pending_words[$];
	wet_pkg::wet_out_t expected_ticks[$];

	int words_queued    = 0;
	int words_taken     = 0;
	int mismatch_count  = 0;
	int quiet_cycles    = 0;
	int feed_idle_pct   = 0;
	int drain_stall_pct = 0;
	int feed_gap        = 0;
	int drain_gap       = 0;

	// encoder state as the block should hold it
	int tick_setting = wet_pkg::TICK_SIZE_RESET;
	int angle_last_seen[wet_pkg::WHEEL_COUNT];
	int remainder_acc[wet_pkg::WHEEL_COUNT];

	// stimulus generator's own notion of where each wheel is
	int gen_angle[wet_pkg::WHEEL_COUNT];

	wheel_encoder_tick_emulator_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// angle change with half-turn wrap, carried remainder, truncating divide
	function automatic wet_pkg::wet_out_t encode_word(input wet_pkg::wet_in_t w);
		wet_pkg::wet_out_t r;
		int divisor;
		int cur;
		int diff;
		int sum;
		int quot;
		logic [wet_pkg::ANGLE_W-1:0] ang[wet_pkg::WHEEL_COUNT];
		logic [wet_pkg::TICKS_W-1:0] tk[wet_pkg::WHEEL_COUNT];
		ang[0] = w.angle_0;
		ang[1] = w.angle_1;
		ang[2] = w.angle_2;
		ang[3] = w.angle_3;
		divisor = (tick_setting == 0) ? 1 : tick_setting;
		for (int i = 0; i < wet_pkg::WHEEL_COUNT; i++) begin
			cur = int'(ang[i]);
			diff = cur - angle_last_seen[i];
			if (diff < WRAP_DROP)
				diff += FULL_TURN;
			sum = remainder_acc[i] + diff;
			quot = sum / divisor;
			remainder_acc[i] = sum - quot * divisor;
			angle_last_seen[i] = cur;
			if (quot > TICKS_MAX)
				quot = TICKS_MAX;
			if (quot < TICKS_MIN)
				quot = TICKS_MIN;
			tk[i] = quot[wet_pkg::TICKS_W-1:0];
		end
		r.step_us_out = w.step_us;
		r.ticks_0 = tk[0];
		r.ticks_1 = tk[1];
		r.ticks_2 = tk[2];
		r.ticks_3 = tk[3];
		return r;
	endfunction

	function automatic wet_pkg::wet_in_t make_word(input bit flag,
			input logic [wet_pkg::STEP_W-1:0] step,
			input int a0, input int a1, input int a2, input int a3);
		wet_pkg::wet_in_t w;
		w.four_wheels = flag;
		w.step_us = step;
		w.angle_0 = a0[wet_pkg::ANGLE_W-1:0];
		w.angle_1 = a1[wet_pkg::ANGLE_W-1:0];
		w.angle_2 = a2[wet_pkg::ANGLE_W-1:0];
		w.angle_3 = a3[wet_pkg::ANGLE_W-1:0];
		return w;
	endfunction

	// mostly smooth rotation, some arbitrary jumps and near half-turn steps
	function automatic int next_angle(input int i);
		int roll;
		int a;
		roll = $urandom_range(0, 99);
		a = gen_angle[i];
		if (roll < 70) begin
			a = (a + $urandom_range(0, 1600) - 800) % FULL_TURN;
		end else if (roll < 85) begin
			a = $urandom_range(0, ANGLE_TOP);
		end else if (roll < 93) begin
			a = (a + FULL_TURN - $urandom_range(14000, 14800)) % FULL_TURN;
		end else begin
			a = (a + $urandom_range(14000, 14800)) % FULL_TURN;
		end
		if (a < 0)
			a += FULL_TURN;
		gen_angle[i] = a;
		return a;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	task automatic queue_word(input wet_pkg::wet_in_t w);
		pending_words.push_back(w);
		words_queued++;
	endtask

	// sender holds off until every word is taken and every result is back
	task automatic wait_drained();
		while (!(words_taken == words_queued && expected_ticks.size() == 0))
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tick_size(input int value);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value[wet_pkg::TICK_W-1:0];
		tick_setting = value & ((1 << wet_pkg::TICK_W) - 1);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int count, input int feed_pct, input int drain_pct);
		wet_pkg::wet_in_t w;
		feed_idle_pct = feed_pct;
		drain_stall_pct = drain_pct;
		for (int n = 0; n < count; n++) begin
			w.four_wheels = ($urandom_range(0, 99) < 92);
			w.step_us = wet_pkg::STEP_W'($urandom());
			w.angle_0 = next_angle(0);
			w.angle_1 = next_angle(1);
			w.angle_2 = next_angle(2);
			w.angle_3 = next_angle(3);
			queue_word(w);
		end
	endtask

	// word driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (feed_gap > 0) begin
					feed_gap <= feed_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0 &&
						$urandom_range(0, 99) < feed_idle_pct) begin
					feed_gap <= $urandom_range(0, 3);
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_word <= pending_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result stall bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (drain_gap > 0) begin
				drain_gap <= drain_gap - 1;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < drain_stall_pct) begin
				drain_gap <= $urandom_range(0, 3);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// monitor: predict on accepted words, compare accepted results, watchdog
	always @(posedge clk) begin : monitor
		wet_pkg::wet_out_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				words_taken++;
				if (in_word.four_wheels)
					expected_ticks.push_back(encode_word(in_word));
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (expected_ticks.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending, step %0d",
						out_word.step_us_out));
				end else begin
					want = expected_ticks.pop_front();
					if (out_word.step_us_out !== want.step_us_out)
						report_mismatch($sformatf("step_us_out got %0d want %0d",
							out_word.step_us_out, want.step_us_out));
					if (out_word.ticks_0 !== want.ticks_0)
						report_mismatch($sformatf("ticks_0 got %0d want %0d",
							out_word.ticks_0, want.ticks_0));
					if (out_word.ticks_1 !== want.ticks_1)
						report_mismatch($sformatf("ticks_1 got %0d want %0d",
							out_word.ticks_1, want.ticks_1));
					if (out_word.ticks_2 !== want.ticks_2)
						report_mismatch($sformatf("ticks_2 got %0d want %0d",
							out_word.ticks_2, want.ticks_2));
					if (out_word.ticks_3 !== want.ticks_3)
						report_mismatch($sformatf("ticks_3 got %0d want %0d",
							out_word.ticks_3, want.ticks_3));
				end
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		for (int i = 0; i < wet_pkg::WHEEL_COUNT; i++) begin
			angle_last_seen[i] = 0;
			remainder_acc[i] = 0;
			gen_angle[i] = 0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at the reset tick size
		feed_idle_pct = 30;
		drain_stall_pct = 30;
		queue_word(make_word(1'b1, 24'h000000, 0, 0, 0, 0));
		queue_word(make_word(1'b1, 24'hFFFFFF, 28799, 28799, 28799, 28799));
		// full-turn wrap by one unit
		queue_word(make_word(1'b1, 24'hAAAAAA, 0, 0, 0, 0));
		queue_word(make_word(1'b1, 24'h555555, 14400, 14400, 14400, 14400));
		// drop of exactly half a turn is not a wrap
		queue_word(make_word(1'b1, 24'h000001, 0, 0, 0, 0));
		queue_word(make_word(1'b1, 24'h000002, 14401, 14401, 14401, 14401));
		// drop just past half a turn wraps
		queue_word(make_word(1'b1, 24'h000003, 0, 0, 0, 0));
		// flag clear: ignored, state kept
		queue_word(make_word(1'b0, 24'hFFFFFF, ANGLE_TOP, ANGLE_TOP, ANGLE_TOP, ANGLE_TOP));
		// angles past the nominal range
		queue_word(make_word(1'b1, 24'h000004, ANGLE_TOP, ANGLE_TOP, ANGLE_TOP, ANGLE_TOP));
		queue_word(make_word(1'b1, 24'h000005, 0, 0, 0, 0));
		// small moves forward then back
		queue_word(make_word(1'b1, 24'h000006, 50, 40, 30, 20));
		queue_word(make_word(1'b1, 24'h000007, 10, 0, 5, 1));
		queue_word(make_word(1'b1, 24'h000008, 28799, 1, 14400, ANGLE_TOP));
		queue_word(make_word(1'b1, 24'h800000, 16384, 8192, 4096, 2048));
		queue_word(make_word(1'b0, 24'h000000, 0, 0, 0, 0));
		run_random(150, 25, 25);

		// unit tick size, largest tick counts
		write_tick_size(1);
		queue_word(make_word(1'b1, 24'h123456, 0, 0, 0, 0));
		queue_word(make_word(1'b1, 24'h654321, ANGLE_TOP, ANGLE_TOP, ANGLE_TOP, ANGLE_TOP));
		queue_word(make_word(1'b1, 24'h0F0F0F, 0, 0, 0, 0));
		run_random(150, 0, 0);

		// zero tick size behaves as one
		write_tick_size(0);
		run_random(150, 40, 10);

		write_tick_size((1 << wet_pkg::TICK_W) - 1);
		run_random(150, 10, 40);

		write_tick_size(2880);
		run_random(150, 25, 25);

		write_tick_size($urandom_range(1, (1 << wet_pkg::TICK_W) - 1));
		run_random(150, 20, 20);

		write_tick_size($urandom_range(1, 200));
		run_random(150, 50, 50);

		// closing stretch without idling
		write_tick_size(wet_pkg::TICK_SIZE_RESET);
		run_random(330, 0, 0);

		wait_drained();
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
